FILE: design/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator.
// Standalone header; needs no package.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
// Check that a condition implies another on the same edge.
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ffba check failed");
// Check that a condition implies another on the next edge.
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ffba check failed");
`endif

FILE: design/ffba_pkg.sv
// Shared constants, types and the sequencer state for the allocator.
// No dependencies.
package ffba_pkg;
    localparam int ArenaBytes    = 65536;
    localparam int MaxFreeBlocks = 64;
    localparam int HeaderBytes   = 8;
    localparam int MinBlockBytes = 16;
    localparam int StoreDepth    = ArenaBytes / 8;
    localparam int IdxW          = $clog2(MaxFreeBlocks);
    localparam int CntW          = IdxW + 1;
    localparam int SAddrW        = $clog2(StoreDepth);

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StNoFit  = 2'd1;
    localparam logic [1:0] StFull   = 2'd2;
    localparam logic       OpAlloc  = 1'b0;
    localparam logic       OpFree   = 1'b1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ARD, S_ACHK, S_SHRD, S_SHWR,
        S_FLEN, S_FPRD, S_FPWR, S_FHEAD, S_DONE
    } t_state;

    typedef struct packed {
        logic        we;
        logic [IdxW-1:0] waddr;
        logic [15:0] woff;
        logic [15:0] wlen;
        logic [IdxW-1:0] raddr;
    } t_list_cmd;
endpackage

FILE: design/ffba_list_ram.sv
// Free list memory: one entry per free block holding offset and length.
// Depends on ffba_pkg.
module ffba_list_ram (
    input  logic                 i_clk,
    input  ffba_pkg::t_list_cmd  i_cmd,
    output logic [15:0]          o_off,
    output logic [15:0]          o_len
);
    import ffba_pkg::*;
    logic [31:0] r_mem [MaxFreeBlocks];
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= {i_cmd.woff, i_cmd.wlen};
        end
        {o_off, o_len} <= r_mem[i_cmd.raddr];
    end
endmodule

FILE: design/ffba_len_store.sv
// Recorded block lengths, indexed by payload offset divided by 8.
// Depends on ffba_pkg.
module ffba_len_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ffba_pkg::SAddrW-1:0] i_waddr,
    input  logic [15:0]               i_wdata,
    input  logic [ffba_pkg::SAddrW-1:0] i_raddr,
    output logic [15:0]               o_rdata
);
    import ffba_pkg::*;
    logic [15:0] r_mem [StoreDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer around two memories.
// Depends on ffba_pkg, ffba_list_ram, ffba_len_store and the defines header.
//
//  channel | direction | handshake           | fields
//  in      | input     | i_valid / o_stall   | operation, request_bytes, free_address
//  out     | output    | o_valid / i_stall   | block_address, status
//
// One item at a time. Allocate visits the free list entry by entry: a read
// through the list memory's registered port (S_ARD), then a check (S_ACHK).
// A removal that closes the gap moves each later entry one place toward the
// head (read in S_SHRD, write in S_SHWR). Free reads the recorded length
// (S_FLEN), moves each entry one place toward the end (S_FPRD, S_FPWR) and
// writes the freed block at the head (S_FHEAD); a full list is reported
// instead. Reset clears the count; the init state sets it to one and writes
// the initial free block. A stalled result holds in the output register; a new item is taken once it is gone.
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_free_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_block_address,
    output logic [1:0]  o_status
);
    import ffba_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_idx, n_idx;
    logic            r_op;
    logic [16:0]     r_need;
    logic [15:0]     r_faddr;
    logic [15:0]     r_out_addr, n_out_addr;
    logic [1:0]      r_out_stat, n_out_stat;
    logic            r_out_valid;

    t_list_cmd   s_cmd;
    logic [15:0] s_off, s_len;
    logic        s_swe;
    logic [SAddrW-1:0] s_swaddr;
    logic [15:0] s_swdata;
    logic [15:0] s_srd;

    ffba_list_ram u_list (.i_clk(i_clk), .i_cmd(s_cmd), .o_off(s_off), .o_len(s_len));
    ffba_len_store u_store (
        .i_clk(i_clk), .i_we(s_swe), .i_waddr(s_swaddr), .i_wdata(s_swdata),
        .i_raddr(r_faddr[SAddrW+2:3]), .o_rdata(s_srd)
    );

    wire s_accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status = r_out_stat;

    // Normalized request: at least the minimum, else rounded up to 8.
    logic [16:0] s_need_in;
    always_comb begin
        if (i_request_bytes < 16'(MinBlockBytes)) begin
            s_need_in = 17'(MinBlockBytes);
        end else begin
            s_need_in = ({1'b0, i_request_bytes} + 17'd7) & ~17'd7;
        end
    end

    logic [17:0] s_tail;
    logic        s_fit, s_whole;
    logic [IdxW-1:0] s_i, s_ip1;
    assign s_fit   = {1'b0, s_len} >= r_need;
    assign s_whole = {2'b0, s_len} < ({1'b0, r_need} + 18'(HeaderBytes + MinBlockBytes));
    assign s_tail  = {2'b0, s_off} + {2'b0, s_len} - {1'b0, r_need};
    assign s_i     = r_idx[IdxW-1:0];
    assign s_ip1   = IdxW'(r_idx + 1'b1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  n_state = S_IDLE;
            S_IDLE:  if (s_accept) begin
                n_state = (i_operation == OpAlloc) ? S_ARD : S_FLEN;
            end
            S_ARD:   n_state = (r_idx < r_count) ? S_ACHK : S_DONE;
            S_ACHK:  begin
                if (!s_fit) n_state = S_ARD;
                else if (s_whole) n_state = S_SHRD;
                else n_state = S_DONE;
            end
            S_SHRD:  n_state = ((r_idx + 1'b1) < r_count) ? S_SHWR : S_DONE;
            S_SHWR:  n_state = S_SHRD;
            S_FLEN:  n_state = (r_count >= CntW'(MaxFreeBlocks)) ? S_DONE : S_FPRD;
            S_FPRD:  n_state = (r_idx == '0) ? S_FHEAD : S_FPWR;
            S_FPWR:  n_state = S_FPRD;
            S_FHEAD: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory commands.
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_out_addr = r_out_addr;
        n_out_stat = r_out_stat;
        s_cmd      = '{we: 1'b0, waddr: s_i, woff: s_off, wlen: s_len, raddr: s_i};
        s_swe      = 1'b0;
        s_swaddr   = s_off[SAddrW+2:3];
        s_swdata   = s_len;
        unique case (r_state)
            S_INIT: begin
                s_cmd.we = 1'b1; s_cmd.waddr = '0;
                s_cmd.woff = 16'(HeaderBytes);
                s_cmd.wlen = 16'(ArenaBytes - HeaderBytes);
                n_count = CntW'(1);
            end
            S_IDLE: if (s_accept) begin
                n_idx = '0; n_out_addr = '0;
                n_out_stat = (i_operation == OpAlloc) ? StNoFit : StOk;
            end
            S_ACHK: if (!s_fit) begin
                n_idx = r_idx + 1'b1;
            end else begin
                n_out_stat = StOk;
                if (s_whole) begin
                    n_out_addr = s_off; s_swe = 1'b1;
                end else begin
                    n_out_addr = s_tail[15:0];
                    // Drop the length write when the tail lies past the store.
                    s_swe = (s_tail[17:16] == 2'b00); s_swaddr = s_tail[SAddrW+2:3];
                    s_swdata = r_need[15:0];
                    s_cmd.we = 1'b1;
                    s_cmd.wlen = 16'({2'b0, s_len} - {1'b0, r_need} - 18'(HeaderBytes));
                end
            end
            S_SHRD: begin
                s_cmd.raddr = s_ip1;
                if ((r_idx + 1'b1) >= r_count) n_count = r_count - 1'b1;
            end
            S_SHWR: begin
                s_cmd.we = 1'b1; n_idx = r_idx + 1'b1;
            end
            S_FLEN: begin
                if (r_count >= CntW'(MaxFreeBlocks)) n_out_stat = StFull;
                else n_idx = r_count;
            end
            S_FPRD: s_cmd.raddr = IdxW'(r_idx - 1'b1);
            S_FPWR: begin
                s_cmd.we = 1'b1; n_idx = r_idx - 1'b1;
            end
            S_FHEAD: begin
                s_cmd.we = 1'b1; s_cmd.waddr = '0;
                s_cmd.woff = r_faddr; s_cmd.wlen = s_srd;
                n_count = r_count + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= '0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx <= n_idx;
            if (r_state == S_DONE) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr <= n_out_addr;
        r_out_stat <= n_out_stat;
        if (s_accept) begin
            r_op <= i_operation;
            r_need <= s_need_in;
            r_faddr <= i_free_address;
        end
    end

    `FFBA_ASSERT_IMP(a_count_range, i_clk, i_rst_n, r_state == S_IDLE, r_count <= CntW'(MaxFreeBlocks))
    `FFBA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, s_accept, o_stall)
    `FFBA_ASSERT_IMP(a_full_only_free, i_clk, i_rst_n, r_out_valid && r_out_stat == StFull, r_op == OpFree)
endmodule
